[hw/rtl/ihex_pkg.sv]
`timescale 1ns / 1ps

package ihex_pkg;

  // Image and fuse geometry
  localparam int unsigned IMAGE_BYTES = 32768;
  localparam int unsigned IMG_AW      = $clog2(IMAGE_BYTES);
  localparam int unsigned FUSE_COUNT  = 15;
  localparam int unsigned FUSE_IW     = 4;
  localparam logic [31:0] FUSE_BASE   = 32'h0030_0000;
  localparam logic [7:0]  ERASED      = 8'hFF;

  // Longest record body in digits, and the counters that follow from it
  localparam int unsigned LINE_MAX = 128;
  localparam int unsigned POS_W    = $clog2(LINE_MAX + 2);
  localparam int unsigned NEED_W   = 10;

  // Digits in the header (length, address, type) and in an offset record
  localparam int unsigned HDR_DIGITS = 8;
  localparam int unsigned EXT_DIGITS = 12;

  // Record types
  localparam logic [7:0] KIND_DATA = 8'h00;
  localparam logic [7:0] KIND_SEG  = 8'h02;
  localparam logic [7:0] KIND_LIN  = 8'h04;

  // Characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Result status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_IMG  = 2'd1,
    OP_FUSE = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       mark;
    logic       err;
    logic       from_img;
  } res_t;

  // Digits the record uses; zero flags a data record outside both regions.
  function automatic logic [NEED_W-1:0] used_digits(logic [7:0] kind, logic [7:0] len,
                                                    logic img_hit, logic fuse_hit);
    logic [NEED_W-1:0] r;
    r = '0;
    if (kind == KIND_DATA) begin
      if (img_hit) begin
        r = NEED_W'(HDR_DIGITS) + {1'b0, len[7:1], 2'b00};
      end else if (fuse_hit) begin
        r = NEED_W'(HDR_DIGITS) + {1'b0, len, 1'b0};
      end
    end else if (kind == KIND_SEG || kind == KIND_LIN) begin
      r = NEED_W'(EXT_DIGITS);
    end else begin
      r = NEED_W'(HDR_DIGITS);
    end
    return r;
  endfunction

  // {valid, value} of an uppercase hex digit
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

[hw/rtl/intel_hex_image_loader.sv]
`timescale 1ns / 1ps

// Intel HEX loader. Each input request carries an op in tuser: a text
// character (op 0), a program image byte read (op 1) or a fuse entry read
// (op 2); op 3 does nothing. Characters build records (length, address,
// type, data; checksum ignored); data records land in a 32 KiB image that
// reads 0xFF until written, or in a 15-entry fuse table at 0x300000, and
// type 2/4 records set the address offset. Every request returns exactly
// one result (status, read byte, fuse changed mark, sticky error), in
// order. One request per cycle is accepted when the erase pass is over and
// the result queue has room; each result is registered in s1_q, then out_q,
// the image being a single-port-write, single-read memory with a registered
// read. After reset the block erases all 32768 image bytes, one byte per
// cycle, with s_axis_tready_o low. A two-entry result queue lets one more
// request in while a result waits on m_axis_tready_i.
module intel_hex_image_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // char_byte[7:0], read_address[22:8], fuse_index[26:23], zero fill
  input  logic [31:0] s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], read_data[9:2], fuse_was_changed[10], error_sticky[11], zero fill
  output logic [15:0] m_axis_tdata_o
);

  // Digit positions that complete a header field
  localparam logic [ihex_pkg::POS_W-1:0] D_LEN   = ihex_pkg::POS_W'(1);
  localparam logic [ihex_pkg::POS_W-1:0] D_ADRHI = ihex_pkg::POS_W'(3);
  localparam logic [ihex_pkg::POS_W-1:0] D_ADRLO = ihex_pkg::POS_W'(5);
  localparam logic [ihex_pkg::POS_W-1:0] D_KIND  = ihex_pkg::POS_W'(7);
  localparam logic [ihex_pkg::POS_W-1:0] D_DATA0 = ihex_pkg::POS_W'(9);

  // Request fields
  logic [7:0]  char_byte;
  logic [14:0] read_address;
  logic [3:0]  fuse_index;
  logic [1:0]  op;

  assign char_byte    = s_axis_tdata_i[7:0];
  assign read_address = s_axis_tdata_i[22:8];
  assign fuse_index   = s_axis_tdata_i[26:23];
  assign op           = s_axis_tuser_i;

  // Erase pass after reset
  logic                       clr_busy_q;
  logic [ihex_pkg::IMG_AW-1:0] clr_addr_q;

  // Parser state
  logic [ihex_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                 acc_q, acc_d;
  logic [7:0]                 len_q, len_d;
  logic [15:0]                raddr_q, raddr_d;
  logic [7:0]                 kind_q, kind_d;
  logic [31:0]                off_q, off_d;
  logic                       err_q, err_d;
  // record address + offset; settles before the type digits complete
  logic [31:0]                tgt_q;

  // Fuse table
  logic [7:0]                 fuse_val_q [ihex_pkg::FUSE_COUNT];
  logic [ihex_pkg::FUSE_COUNT-1:0] fuse_mark_q;

  // Image memory
  logic [7:0]                  img_mem [ihex_pkg::IMAGE_BYTES];
  logic [7:0]                  rd_q;
  logic                        mem_we, mem_re, img_we;
  logic [ihex_pkg::IMG_AW-1:0] mem_wa, img_wa, mem_ra;
  logic [7:0]                  mem_wd;

  logic                        fuse_we;
  logic [ihex_pkg::FUSE_IW-1:0] fuse_wa;

  // Result queue
  ihex_pkg::res_t s1_q, s1_d, out_q, out_d;
  logic           s1_valid_q, out_valid_q;
  logic           accept, s1_adv, in_ready;
  logic [1:0]     status;

  // Parser datapath
  logic [ihex_pkg::POS_W-1:0]  d, dk;
  logic [ihex_pkg::POS_W-2:0]  k;
  logic [ihex_pkg::NEED_W-1:0] need_cur, need_new, dx;
  logic                        img_hit, fuse_hit;
  logic [4:0]                  hex;
  logic [7:0]                  acc_nx;
  logic [ihex_pkg::IMG_AW:0]   img_sum;
  logic [ihex_pkg::POS_W:0]    fuse_sum;
  logic                        fail;

  assign in_ready = !clr_busy_q && (!s1_valid_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = in_ready;
  assign accept   = s_axis_tvalid_i && in_ready;
  assign s1_adv   = s1_valid_q && (!out_valid_q || m_axis_tready_i);

  assign img_hit  = tgt_q < 32'(ihex_pkg::IMAGE_BYTES);
  assign fuse_hit = (tgt_q >= ihex_pkg::FUSE_BASE) &&
                    (tgt_q < ihex_pkg::FUSE_BASE + 32'(ihex_pkg::FUSE_COUNT));

  assign d        = pos_q - ihex_pkg::POS_W'(1);
  assign dx       = ihex_pkg::NEED_W'(d);
  assign dk       = d - D_DATA0;
  assign k        = dk[ihex_pkg::POS_W-1:1];
  assign hex      = ihex_pkg::hex_digit(char_byte);
  assign acc_nx   = {acc_q[3:0], hex[3:0]};
  assign need_cur = ihex_pkg::used_digits(kind_q, len_q, img_hit, fuse_hit);
  assign need_new = ihex_pkg::used_digits(acc_nx, len_q, img_hit, fuse_hit);
  assign img_sum  = {1'b0, tgt_q[ihex_pkg::IMG_AW-1:0]} + (ihex_pkg::IMG_AW + 1)'(k);
  assign fuse_sum = (ihex_pkg::POS_W + 1)'(tgt_q[ihex_pkg::FUSE_IW-1:0]) +
                    (ihex_pkg::POS_W + 1)'(k);

  // Character parser
  always_comb begin
    pos_d   = pos_q;
    acc_d   = acc_q;
    len_d   = len_q;
    raddr_d = raddr_q;
    kind_d  = kind_q;
    off_d   = off_q;
    status  = ihex_pkg::ST_BUSY;
    fail    = 1'b0;
    img_we  = 1'b0;
    img_wa  = img_sum[ihex_pkg::IMG_AW-1:0];
    fuse_we = 1'b0;
    fuse_wa = fuse_sum[ihex_pkg::FUSE_IW-1:0];
    if (accept && op == ihex_pkg::OP_CHAR) begin
      if (pos_q == '0) begin
        if (char_byte == ihex_pkg::CH_COLON) begin
          pos_d = ihex_pkg::POS_W'(1);
          acc_d = '0;
        end
      end else if (char_byte == ihex_pkg::CH_NL) begin
        if (dx < ihex_pkg::NEED_W'(ihex_pkg::HDR_DIGITS) || dx < need_cur) begin
          fail = 1'b1;
        end else begin
          pos_d  = '0;
          status = ihex_pkg::ST_DONE;
        end
      end else if (dx >= ihex_pkg::NEED_W'(ihex_pkg::HDR_DIGITS) && dx >= need_cur) begin
        // checksum and trailing text: ignored until newline
      end else if (!hex[4]) begin
        fail = 1'b1;
      end else begin
        acc_d = acc_nx;
        pos_d = pos_q + ihex_pkg::POS_W'(1);
        if (d[0]) begin
          if (d == D_LEN) begin
            len_d = acc_d;
          end else if (d == D_ADRHI) begin
            raddr_d[15:8] = acc_d;
          end else if (d == D_ADRLO) begin
            raddr_d[7:0] = acc_d;
          end else if (d == D_KIND) begin
            kind_d = acc_d;
            if (need_new == '0 || need_new > ihex_pkg::NEED_W'(ihex_pkg::LINE_MAX)) begin
              fail = 1'b1;
            end
          end else if (kind_q == ihex_pkg::KIND_DATA) begin
            if (img_hit) begin
              img_we = !img_sum[ihex_pkg::IMG_AW];
            end else if (fuse_hit) begin
              fuse_we = fuse_sum < (ihex_pkg::POS_W + 1)'(ihex_pkg::FUSE_COUNT);
            end
          end else if (kind_q == ihex_pkg::KIND_LIN) begin
            if (k == '0) off_d = {acc_d, 24'h0};
            else         off_d = off_q | {8'h0, acc_d, 16'h0};
          end else if (kind_q == ihex_pkg::KIND_SEG) begin
            if (k == '0) off_d = {12'h0, acc_d, 12'h0};
            else         off_d = off_q | {20'h0, acc_d, 4'h0};
          end
        end
      end
      if (fail) begin
        pos_d  = '0;
        status = ihex_pkg::ST_ERR;
      end
    end
  end

  assign err_d = err_q | fail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      acc_q   <= '0;
      len_q   <= '0;
      raddr_q <= '0;
      kind_q  <= '0;
      off_q   <= '0;
      err_q   <= 1'b0;
      tgt_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      raddr_q <= raddr_d;
      kind_q  <= kind_d;
      off_q   <= off_d;
      err_q   <= err_d;
      tgt_q   <= {16'h0, raddr_q} + off_q;
    end
  end

  // Erase sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ihex_pkg::IMG_AW'(1);
      if (clr_addr_q == ihex_pkg::IMG_AW'(ihex_pkg::IMAGE_BYTES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Image memory port: erase sweep or parser write, one read
  assign mem_we = clr_busy_q || img_we;
  assign mem_wa = clr_busy_q ? clr_addr_q : img_wa;
  assign mem_wd = clr_busy_q ? ihex_pkg::ERASED : acc_d;
  assign mem_re = accept && op == ihex_pkg::OP_IMG;
  assign mem_ra = ihex_pkg::IMG_AW'(read_address);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      img_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= img_mem[mem_ra];
    end
  end

  // Fuse table
  always_ff @(posedge clk_i) begin
    if (fuse_we) begin
      fuse_val_q[fuse_wa] <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fuse_mark_q <= '0;
    end else if (fuse_we) begin
      fuse_mark_q[fuse_wa] <= 1'b1;
    end
  end

  // First result stage; image byte joins from rd_q on the way out
  always_comb begin
    s1_d          = '0;
    s1_d.status   = status;
    s1_d.err      = err_d;
    s1_d.from_img = op == ihex_pkg::OP_IMG;
    if (op == ihex_pkg::OP_FUSE && 32'(fuse_index) < 32'(ihex_pkg::FUSE_COUNT)) begin
      s1_d.data = fuse_val_q[fuse_index];
      s1_d.mark = fuse_mark_q[fuse_index];
    end
  end

  always_comb begin
    out_d = s1_q;
    if (s1_q.from_img) begin
      out_d.data = rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept)      s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv)               out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'h0, out_q.err, out_q.mark, out_q.data, out_q.status};

endmodule

[tb/intel_hex_image_loader_tb.sv]
`timescale 1ns / 1ps

// Intel HEX loader bench. Requests are driven on the falling edge and
// checked on the rising edge. Every accepted request is pushed through a
// local copy of the parser/image/fuse behavior. The resulting response goes
// into a queue that the output side drains in order.
module intel_hex_image_loader_tb;
  import ihex_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned N_DIRECTED   = 26;

  // One response as the block reports it
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       mark;
    logic       err;
  } loader_resp_t;

  // One row of the directed table; typed rows carry their own answer
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic [14:0] raddr;
    logic [3:0] fidx;
    logic       typed;
    logic [1:0] status;
    logic [7:0] data;
    logic       err;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // char_byte[7:0], read_address[22:8], fuse_index[26:23]
  logic [1:0]  s_axis_tuser;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // status[1:0], read_data[9:2], fuse_was_changed[10],
                               // error_sticky[11]

  // Local copy of the block's state
  logic [7:0]  image_mem [IMAGE_BYTES];
  logic [7:0]  fuse_val [FUSE_COUNT];
  logic        fuse_mark [FUSE_COUNT];
  logic [31:0] addr_offset;
  int unsigned char_pos;       // 0 outside a record, else digits seen + 1
  logic [7:0]  digit_acc;
  logic [7:0]  rec_len;
  logic [15:0] rec_addr;
  logic [7:0]  rec_kind;
  logic        err_flag;

  loader_resp_t  pending_responses [$];
  loader_resp_t  typed_resp;
  logic          typed_check;
  directed_row_t directed_rows [N_DIRECTED];
  logic [7:0]    line_buf [$];

  int unsigned accepted_reqs;
  int unsigned checked_results;
  int unsigned mismatches;
  int unsigned elapsed_cycles;
  int unsigned stim_items;
  int unsigned records_closed;
  int unsigned error_results;
  int unsigned image_reads;
  int unsigned fuse_reads;
  logic [31:0] last_target;
  logic        calm_stretch;   // no random gaps on either side while set

  intel_hex_image_loader i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Expected behavior
  // ---------------------------------------------------------------------

  function automatic void clear_loader_state();
    for (int i = 0; i < IMAGE_BYTES; i++) image_mem[i] = ERASED;
    for (int i = 0; i < FUSE_COUNT; i++) begin
      fuse_val[i]  = 8'h00;
      fuse_mark[i] = 1'b0;
    end
    addr_offset = '0;
    char_pos    = 0;
    digit_acc   = '0;
    rec_len     = '0;
    rec_addr    = '0;
    rec_kind    = '0;
    err_flag    = 1'b0;
  endfunction

  function automatic int digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  // Record address plus offset, 32-bit wrap
  function automatic logic [31:0] write_target();
    return {16'h0000, rec_addr} + addr_offset;
  endfunction

  // Digits the open record consumes; 0 = data record hitting neither region
  function automatic int unsigned digits_in_use();
    logic [31:0] a;
    a = write_target();
    if (rec_kind == KIND_DATA) begin
      if (a < IMAGE_BYTES) return 8 + 2 * int'(rec_len & 8'hFE);
      if (a >= FUSE_BASE && a < FUSE_BASE + FUSE_COUNT) return 8 + 2 * int'(rec_len);
      return 0;
    end
    if (rec_kind == KIND_SEG || rec_kind == KIND_LIN) return 12;
    return 8;
  endfunction

  function automatic logic [1:0] abandon_record();
    err_flag = 1'b1;
    char_pos = 0;
    return ST_ERR;
  endfunction

  function automatic void store_byte(int unsigned k, logic [7:0] b);
    logic [31:0] a;
    logic [31:0] idx;
    a = write_target();
    if (rec_kind == KIND_DATA) begin
      if (a < IMAGE_BYTES) begin
        // bytes running past the top of the image are dropped
        if (a + k < IMAGE_BYTES) image_mem[a + k] = b;
      end else begin
        idx = a - FUSE_BASE + k;
        if (idx < FUSE_COUNT) begin
          fuse_val[idx]  = b;
          fuse_mark[idx] = 1'b1;
        end
      end
    end else if (rec_kind == KIND_LIN) begin
      if (k == 0) addr_offset = {b, 24'h000000};
      else        addr_offset = addr_offset | {8'h00, b, 16'h0000};
    end else if (rec_kind == KIND_SEG) begin
      if (k == 0) addr_offset = {12'h000, b, 12'h000};
      else        addr_offset = addr_offset | {20'h00000, b, 4'h0};
    end
  endfunction

  function automatic logic [1:0] parse_char(logic [7:0] c);
    int unsigned d;
    int unsigned need;
    int          v;
    if (char_pos == 0) begin
      if (c == CH_COLON) begin
        char_pos  = 1;
        digit_acc = '0;
      end
      return ST_BUSY;
    end
    d = char_pos - 1;
    if (c == CH_NL) begin
      if (d < 8 || d < digits_in_use()) return abandon_record();
      char_pos = 0;
      return ST_DONE;
    end
    // checksum and trailing text are skipped up to the newline
    if (d >= 8 && d >= digits_in_use()) return ST_BUSY;
    v = digit_of(c);
    if (v < 0) return abandon_record();
    digit_acc = {digit_acc[3:0], 4'(v)};
    char_pos  = d + 2;
    if (d[0] == 1'b0) return ST_BUSY;
    case (d)
      1: rec_len = digit_acc;
      3: rec_addr = {digit_acc, 8'h00};
      5: rec_addr[7:0] = digit_acc;
      7: begin
        rec_kind = digit_acc;
        need     = digits_in_use();
        if (need == 0 || need > LINE_MAX) return abandon_record();
      end
      default: store_byte((d - 9) / 2, digit_acc);
    endcase
    return ST_BUSY;
  endfunction

  function automatic loader_resp_t loader_response(op_e op, logic [7:0] ch,
                                                   logic [14:0] raddr, logic [3:0] fidx);
    loader_resp_t r;
    r = '0;
    case (op)
      OP_CHAR: r.status = parse_char(ch);
      OP_IMG:  r.data   = image_mem[raddr];
      OP_FUSE: begin
        if (fidx < FUSE_COUNT) begin
          r.data = fuse_val[fidx];
          r.mark = fuse_mark[fidx];
        end
      end
      default: ;
    endcase
    r.err = err_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: push on request accept, pop and compare on result accept
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    loader_resp_t predicted;
    loader_resp_t observed;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predicted = loader_response(op_e'(s_axis_tuser), s_axis_tdata[7:0],
                                  s_axis_tdata[22:8], s_axis_tdata[26:23]);
      if (typed_check) predicted = typed_resp;
      pending_responses.push_back(predicted);
      accepted_reqs++;
      if (op_e'(s_axis_tuser) == OP_CHAR && predicted.status == ST_DONE) records_closed++;
      if (predicted.status == ST_ERR) error_results++;
      if (op_e'(s_axis_tuser) == OP_IMG) image_reads++;
      if (op_e'(s_axis_tuser) == OP_FUSE) fuse_reads++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      observed.status = m_axis_tdata[1:0];
      observed.data   = m_axis_tdata[9:2];
      observed.mark   = m_axis_tdata[10];
      observed.err    = m_axis_tdata[11];
      if (pending_responses.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: tdata %04h", m_axis_tdata);
        mismatches++;
      end else begin
        predicted = pending_responses.pop_front();
        if (observed.status !== predicted.status || observed.data !== predicted.data ||
            observed.mark !== predicted.mark || observed.err !== predicted.err) begin
          if (mismatches < 10) begin
            $display("mismatch at result %0d: exp st %0d data %02h mark %0b err %0b",
                     checked_results, predicted.status, predicted.data, predicted.mark,
                     predicted.err);
            $display("                         got st %0d data %02h mark %0b err %0b",
                     observed.status, observed.data, observed.mark, observed.err);
          end
          mismatches++;
        end
      end
      checked_results++;
    end
  end

  // Hang guard; covers the post-reset erase pass too
  always @(posedge clk_i) begin
    elapsed_cycles++;
    if (elapsed_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", elapsed_cycles,
               pending_responses.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  function automatic directed_row_t row(op_e op, logic [7:0] ch, logic [14:0] raddr,
                                        logic [3:0] fidx, logic typed, logic [1:0] st,
                                        logic [7:0] data, logic err);
    directed_row_t r;
    r.op     = op;
    r.ch     = ch;
    r.raddr  = raddr;
    r.fidx   = fidx;
    r.typed  = typed;
    r.status = st;
    r.data   = data;
    r.err    = err;
    return r;
  endfunction

  // Offer one request and hold it until the block takes it. Fields that the
  // op ignores carry random junk.
  task automatic send_request(input op_e op, input logic [7:0] ch, input logic [14:0] raddr,
                              input logic [3:0] fidx, input logic typed,
                              input loader_resp_t tr);
    int unsigned gap;
    int unsigned seen;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (op != OP_CHAR) ch = 8'($urandom);
    if (op != OP_IMG) raddr = 15'($urandom);
    if (op != OP_FUSE) fidx = 4'($urandom);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b00000, fidx, raddr, ch};
    typed_check   = typed;
    typed_resp    = tr;
    seen          = accepted_reqs;
    do @(negedge clk_i); while (accepted_reqs == seen);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_request(OP_CHAR, c, '0, '0, 1'b0, '0);
  endtask

  task automatic push_hex(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
  endtask

  // Build one text line: mostly well-formed records that reach the current
  // region, some stray addresses, long records, other types and damaged lines.
  task automatic build_record();
    logic [7:0]  len;
    logic [7:0]  kind;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] a16;
    logic [31:0] tgt;
    logic [31:0] low_bound;
    int unsigned r;
    int unsigned p;
    line_buf.delete();
    line_buf.push_back(CH_COLON);
    r = $urandom_range(0, 99);
    if (r < 20) begin
      // offset record: zero, fuse window, small segment, or anything
      p = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0) begin
        kind = KIND_LIN;
        hi   = (p == 9) ? 8'($urandom) : 8'h00;
        lo   = (p < 5) ? 8'h00 : (p < 8) ? 8'h30 : 8'($urandom);
      end else begin
        kind = KIND_SEG;
        hi   = (p < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        lo   = 8'($urandom);
      end
      len = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h02;
      push_hex(len);
      push_hex(8'($urandom));
      push_hex(8'($urandom));
      push_hex(kind);
      push_hex(hi);
      push_hex(lo);
    end else if (r < 75) begin
      if (addr_offset == FUSE_BASE) begin
        len = 8'($urandom_range(1, 15));
        a16 = 16'($urandom_range(0, 14));
      end else if (addr_offset < IMAGE_BYTES) begin
        // lengths 60/61 just fit the line limit, 62/63 do not
        len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 63))
                                          : 8'($urandom_range(0, 16));
        if ($urandom_range(0, 4) == 0) begin
          low_bound = (addr_offset > IMAGE_BYTES - 24) ? addr_offset : IMAGE_BYTES - 24;
        end else begin
          low_bound = addr_offset;
        end
        tgt = $urandom_range(IMAGE_BYTES - 1, low_bound);
        a16 = 16'(tgt - addr_offset);
      end else begin
        len = 8'($urandom_range(0, 8));
        a16 = 16'($urandom);
      end
      if ($urandom_range(0, 19) == 0) a16 = 16'($urandom);
      last_target = {16'h0000, a16} + addr_offset;
      push_hex(len);
      push_hex(a16[15:8]);
      push_hex(a16[7:0]);
      push_hex(KIND_DATA);
      repeat (len) push_hex(8'($urandom));
    end else begin
      p = $urandom_range(0, 3);
      kind = (p == 0) ? 8'h01 : (p == 1) ? 8'h03 : (p == 2) ? 8'h05 : 8'($urandom);
      len  = 8'($urandom_range(0, 8));
      push_hex(len);
      push_hex(8'($urandom));
      push_hex(8'($urandom));
      push_hex(kind);
      repeat (len) push_hex(8'($urandom));
    end
    push_hex(8'($urandom));  // checksum, never checked
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    line_buf.push_back(CH_NL);
    // damage: lowercase digit, arbitrary byte, or early newline
    if ($urandom_range(0, 6) == 0) begin
      p = $urandom_range(1, line_buf.size() - 2);
      case ($urandom_range(0, 2))
        0: line_buf[p] = 8'($urandom_range(8'h61, 8'h66));
        1: line_buf[p] = 8'($urandom);
        default: begin
          while (line_buf.size() > p) void'(line_buf.pop_back());
          line_buf.push_back(CH_NL);
        end
      endcase
    end
  endtask

  // A few reads after a line: near the last write, anywhere, fuses, op 3
  task automatic send_reads();
    int unsigned p;
    logic [3:0]  idx;
    repeat ($urandom_range(1, 3)) begin
      p = $urandom_range(0, 9);
      if (p < 5) begin
        send_request(OP_IMG, '0, (p < 3) ? 15'(last_target + $urandom_range(0, 31))
                                         : 15'($urandom), '0, 1'b0, '0);
      end else if (p < 9) begin
        // never read a fuse entry that no record has written
        idx = 4'($urandom_range(0, 15));
        if (idx < FUSE_COUNT && !fuse_mark[idx]) idx = 4'd15;
        send_request(OP_FUSE, '0, '0, idx, 1'b0, '0);
      end else begin
        send_request(OP_NONE, '0, '0, '0, 1'b0, '0);
      end
      stim_items++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random ready with one long hold-off to back up the block
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    logic        held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
      if (!held && checked_results >= 300) begin
        held          = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    loader_resp_t tr;
    logic [7:0]   c;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tuser    = OP_NONE;
    s_axis_tdata    = '0;
    typed_check     = 1'b0;
    typed_resp      = '0;
    accepted_reqs   = 0;
    checked_results = 0;
    mismatches      = 0;
    elapsed_cycles  = 0;
    stim_items      = 0;
    records_closed  = 0;
    error_results   = 0;
    image_reads     = 0;
    fuse_reads      = 0;
    last_target     = '0;
    calm_stretch    = 1'b0;
    clear_loader_state();

    directed_rows = '{
      // erased image at both ends, out-of-table fuse, op 3, stray newline
      row(OP_IMG,  8'h00,  15'h0000, 4'd0,  1'b1, ST_BUSY, ERASED, 1'b0),
      row(OP_IMG,  8'h00,  15'h7FFF, 4'd0,  1'b1, ST_BUSY, ERASED, 1'b0),
      row(OP_FUSE, 8'h00,  15'h0000, 4'd15, 1'b1, ST_BUSY, 8'h00,  1'b0),
      row(OP_NONE, 8'h00,  15'h0000, 4'd0,  1'b1, ST_BUSY, 8'h00,  1'b0),
      row(OP_CHAR, CH_NL,  15'h0000, 4'd0,  1'b1, ST_BUSY, 8'h00,  1'b0),
      // end-of-file record (type 01) closes cleanly
      row(OP_CHAR, CH_COLON, 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "1", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, CH_NL, 15'h0, 4'd0, 1'b1, ST_DONE, 8'h00, 1'b0),
      // lowercase digit is rejected, error sticks from here on
      row(OP_CHAR, CH_COLON, 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "a", 15'h0, 4'd0, 1'b1, ST_ERR, 8'h00, 1'b1),
      // length 0x3E needs 132 digits: over the line limit at the type byte
      row(OP_CHAR, CH_COLON, 15'h0, 4'd0, 1'b1, ST_BUSY, 8'h00, 1'b1),
      row(OP_CHAR, "3", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "E", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b0, ST_BUSY, 8'h00, 1'b0),
      row(OP_CHAR, "0", 15'h0, 4'd0, 1'b1, ST_ERR, 8'h00, 1'b1)
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first accept waits out the erase pass (tready low)
    foreach (directed_rows[i]) begin
      tr        = '0;
      tr.status = directed_rows[i].status;
      tr.data   = directed_rows[i].data;
      tr.err    = directed_rows[i].err;
      send_request(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].raddr,
                   directed_rows[i].fidx, directed_rows[i].typed, tr);
    end

    while (stim_items < RANDOM_ITEMS) begin
      calm_stretch = ($urandom_range(0, 7) == 0);
      // leading junk outside a record (no colon, so the line stays intact)
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 4)) begin
          c = 8'($urandom);
          if (c == CH_COLON) c = 8'h20;
          send_char(c);
        end
      end
      build_record();
      foreach (line_buf[i]) begin
        send_char(line_buf[i]);
        stim_items++;
      end
      if ($urandom_range(0, 9) < 4) send_reads();
    end
    calm_stretch  = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_responses.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Run covered %0d requests: %0d records closed, %0d error results,",
             accepted_reqs, records_closed, error_results);
    $display("%0d image reads, %0d fuse reads, and a %0d-cycle result hold-off.",
             image_reads, fuse_reads, HOLD_CYCLES);
    if (pending_responses.size() != 0) begin
      $display("%0d expected results never arrived", pending_responses.size());
    end
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
